>>> rtl/w3mf_pkg.sv
// Shared constants and types for the 3x3 mean/median window filter.
// No dependencies; imported by the top level.
package w3mf_pkg;

	// Width of every configuration register.
	localparam int CFG_W = 12;

	// Smallest usable row length and frame height.
	localparam int MIN_LINE = 3;
	localparam int MIN_ROWS = 3;

	// Tallest frame the row counters support.
	localparam int MAX_HEIGHT = 2048;
	localparam int ORW        = $clog2(MAX_HEIGHT);

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] RST_LINE_WIDTH   = 12'd640;
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
	localparam logic [CFG_W-1:0] RST_MEAN_END     = 12'd213;
	localparam logic [CFG_W-1:0] RST_MEDIAN_START = 12'd426;

	// Register index, taken from the word address.
	typedef enum logic [1:0] {
		REG_LINE_WIDTH,
		REG_FRAME_HEIGHT,
		REG_MEAN_END,
		REG_MEDIAN_START
	} cfg_reg_t;

	// Which filter an output position gets.
	typedef enum logic [1:0] {
		MODE_MEAN,
		MODE_MEDIAN,
		MODE_PASS
	} filt_mode_t;

endpackage

>>> rtl/w3mf_pix_in_if.sv
// Input channel of the window filter: one pixel word or flush marker.
// Depends on nothing.
interface w3mf_pix_in_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_value;
	logic                  flush;

	modport source (output valid, output pixel_value, output flush, input ready);
	modport sink   (input valid, input pixel_value, input flush, output ready);
endinterface

>>> rtl/w3mf_pix_out_if.sv
// Output channel of the window filter: one filtered pixel word with row and
// frame end flags. Depends on nothing.
interface w3mf_pix_out_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] filtered_value;
	logic                  end_of_line;
	logic                  end_of_frame;

	modport source (output valid, output filtered_value, output end_of_line,
		output end_of_frame, input ready);
	modport sink   (input valid, input filtered_value, input end_of_line,
		input end_of_frame, output ready);
endinterface

>>> rtl/window_3x3_mean_median_filter.sv
// 3x3 mean/median window filter on a raster pixel stream.
// Pipeline: the stage 1 registers and the line-buffer read take a word at its accepting
// edge, then come the window taps, the sum and first median half, and the output register
// after the divide and second median half, where the result is valid. Results trail the
// input by one row plus one pixel. Throughput: one word per clock unless the output
// stalls; the line buffers are read once per word and written once per word outside the
// drain rows. Reset clears counters, window and pipeline and reloads the register
// defaults; the line buffers are not cleared and need no clearing pass.
module window_3x3_mean_median_filter
	import w3mf_pkg::*;
#(
	parameter int MAX_LINE   = 2048,
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	w3mf_pix_in_if.sink           pix_in,
	w3mf_pix_out_if.source        pix_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int CW   = $clog2(MAX_LINE);
	localparam int CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int SW   = PIXEL_BITS + 4;
	localparam int K    = SW + 4;
	localparam int PW   = 2 * SW + 1;
	localparam logic [SW:0] RECIP = (SW + 1)'((2 ** K + 8) / 9);

	// Configuration registers.
	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CFG_W-1:0] mean_end_q;
	logic [CFG_W-1:0] median_start_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= RST_LINE_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			mean_end_q     <= RST_MEAN_END;
			median_start_q <= RST_MEDIAN_START;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[3:2]))
				REG_LINE_WIDTH:   line_width_q   <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				REG_MEAN_END:     mean_end_q     <= pwdata[CFG_W-1:0];
				REG_MEDIAN_START: median_start_q <= pwdata[CFG_W-1:0];
				default:          ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_reg_t'(paddr[3:2]))
			REG_LINE_WIDTH:   prdata = 32'(line_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_MEAN_END:     prdata = 32'(mean_end_q);
			REG_MEDIAN_START: prdata = 32'(median_start_q);
			default:          prdata = '0;
		endcase
	end

	// Effective row length and frame height after clamping.
	logic [CMPW-1:0]  lw_ext;
	logic [CMPW-1:0]  w_eff;
	logic [CFG_W-1:0] h_eff;

	always_comb begin
		lw_ext = CMPW'(line_width_q);
		if (lw_ext < CMPW'(MIN_LINE)) begin
			w_eff = CMPW'(MIN_LINE);
		end else if (lw_ext > CMPW'(MAX_LINE)) begin
			w_eff = CMPW'(MAX_LINE);
		end else begin
			w_eff = lw_ext;
		end
		if (frame_height_q < CFG_W'(MIN_ROWS)) begin
			h_eff = CFG_W'(MIN_ROWS);
		end else if (frame_height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// Pipeline advance: everything moves when the output register is free.
	logic en;
	logic accept;
	logic out_valid_q;

	assign en           = !out_valid_q || pix_out.ready;
	assign pix_in.ready = en;
	assign accept       = pix_in.valid && en;

	// Position counters and per-word decisions at acceptance.
	logic [CW-1:0]    in_col_q;
	logic [CFG_W-1:0] in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [ORW-1:0]   out_row_q;
	logic             drain;
	logic             take;
	logic             emit;
	logic             in_wrap;
	logic             eol;
	logic             eof;
	filt_mode_t       mode;

	always_comb begin
		drain   = in_row_q >= h_eff;
		take    = accept && (drain || !pix_in.flush);
		emit    = (in_row_q >= CFG_W'(2)) || (in_row_q == CFG_W'(1) && in_col_q != '0);
		in_wrap = (CMPW'(in_col_q) + CMPW'(1)) >= w_eff;
		eol     = (CMPW'(out_col_q) + CMPW'(1)) >= w_eff;
		eof     = eol && ((CFG_W'(out_row_q) + CFG_W'(1)) >= h_eff);
		if (CMPW'(out_col_q) >= CMPW'(median_start_q)) begin
			mode = MODE_MEDIAN;
		end else if (CMPW'(out_col_q) < CMPW'(mean_end_q)) begin
			mode = MODE_MEAN;
		end else begin
			mode = MODE_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (emit && eof) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + CFG_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (eol) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ORW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Stage 1 registers: the word and its decisions, alongside the buffer read.
	logic                  valid_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         addr_s1;
	logic                  drain_s1;
	logic                  rowlt2_s1;
	logic                  colzero_s1;
	logic                  emit_s1;
	filt_mode_t            mode_s1;
	logic                  eol_s1;
	logic                  eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1     <= pix_in.pixel_value;
			addr_s1    <= in_col_q;
			drain_s1   <= drain;
			rowlt2_s1  <= in_row_q < CFG_W'(2);
			colzero_s1 <= in_col_q == '0;
			emit_s1    <= emit;
			mode_s1    <= mode;
			eol_s1     <= eol;
			eof_s1     <= eof;
		end
	end

	// Line buffers: previous row and the row before it.
	logic [PIXEL_BITS-1:0] mid_rd;
	logic [PIXEL_BITS-1:0] top_rd;

	w3mf_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_LINE)
	) u_mid_ram (
		.clk   (clk),
		.we    (take && !drain),
		.waddr (in_col_q),
		.wdata (pix_in.pixel_value),
		.re    (take),
		.raddr (in_col_q),
		.rdata (mid_rd)
	);

	w3mf_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (MAX_LINE)
	) u_top_ram (
		.clk   (clk),
		.we    (valid_s1 && en && !drain_s1),
		.waddr (addr_s1),
		.wdata (mid_rd),
		.re    (take),
		.raddr (in_col_q),
		.rdata (top_rd)
	);

	// New column of the window and the taps the filter sees.
	logic [PIXEL_BITS-1:0] window_q [9];
	logic [PIXEL_BITS-1:0] col_new [3];
	logic [PIXEL_BITS-1:0] taps [9];
	logic [PIXEL_BITS-1:0] window_nxt [9];

	always_comb begin
		col_new[0] = rowlt2_s1 ? mid_rd : top_rd;
		col_new[1] = mid_rd;
		col_new[2] = drain_s1 ? mid_rd : pix_s1;
		for (int r = 0; r < 3; r++) begin
			taps[r*3]     = window_q[r*3+1];
			taps[r*3+1]   = window_q[r*3+2];
			taps[r*3+2]   = colzero_s1 ? window_q[r*3+2] : col_new[r];
			// A row start fills the window with the first column replicated.
			window_nxt[r*3]   = colzero_s1 ? col_new[r] : taps[r*3];
			window_nxt[r*3+1] = colzero_s1 ? col_new[r] : taps[r*3+1];
			window_nxt[r*3+2] = col_new[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '{default: '0};
		end else if (valid_s1 && en) begin
			window_q <= window_nxt;
		end
	end

	// Stage 2 registers: the nine taps of an emitting word.
	logic                  valid_s2;
	logic [PIXEL_BITS-1:0] taps_s2 [9];
	filt_mode_t            mode_s2;
	logic                  eol_s2;
	logic                  eof_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			taps_s2 <= taps;
			mode_s2 <= mode_s1;
			eol_s2  <= eol_s1;
			eof_s2  <= eof_s1;
		end
	end

	// Sum of the nine taps.
	logic [SW-1:0] sum;

	always_comb begin
		sum = '0;
		for (int i = 0; i < 9; i++) begin
			sum = sum + SW'(taps_s2[i]);
		end
	end

	// Stage 3 registers: sum, centre pixel and flags.
	logic                  valid_s3;
	logic [SW-1:0]         sum_s3;
	logic [PIXEL_BITS-1:0] center_s3;
	filt_mode_t            mode_s3;
	logic                  eol_s3;
	logic                  eof_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3    <= sum;
			center_s3 <= taps_s2[4];
			mode_s3   <= mode_s2;
			eol_s3    <= eol_s2;
			eof_s3    <= eof_s2;
		end
	end

	// Median network, registered internally alongside the stage 3 registers.
	logic [PIXEL_BITS-1:0] median;

	w3mf_median9 #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_median (
		.clk    (clk),
		.en     (en),
		.taps   (taps_s2),
		.median (median)
	);

	// Truncated mean: divide by nine through a reciprocal multiply.
	logic [PW-1:0]         prod;
	logic [PIXEL_BITS-1:0] mean;
	logic [PIXEL_BITS-1:0] result;

	assign prod = PW'(sum_s3) * PW'(RECIP);
	assign mean = prod[K +: PIXEL_BITS];

	always_comb begin
		case (mode_s3)
			MODE_MEDIAN: result = median;
			MODE_MEAN:   result = mean;
			MODE_PASS:   result = center_s3;
			default:     result = center_s3;
		endcase
	end

	// Output register.
	logic [PIXEL_BITS-1:0] out_value_q;
	logic                  out_eol_q;
	logic                  out_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s3) begin
			out_value_q <= result;
			out_eol_q   <= eol_s3;
			out_eof_q   <= eof_s3;
		end
	end

	assign pix_out.valid          = out_valid_q;
	assign pix_out.filtered_value = out_value_q;
	assign pix_out.end_of_line    = out_eol_q;
	assign pix_out.end_of_frame   = out_eof_q;

endmodule

>>> rtl/w3mf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. Depends on nothing.
module w3mf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/w3mf_median9.sv
// Median of nine values through a 19-exchange sorting network, split over
// one internal register stage. Depends on nothing.
module w3mf_median9 #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [PIXEL_BITS-1:0] taps [9],
	output logic [PIXEL_BITS-1:0] median
);

	// First half sorts each group of three; second half merges.
	localparam int A_LO [9]  = '{1, 4, 7, 0, 3, 6, 1, 4, 7};
	localparam int A_HI [9]  = '{2, 5, 8, 1, 4, 7, 2, 5, 8};
	localparam int B_LO [10] = '{0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
	localparam int B_HI [10] = '{3, 8, 7, 6, 4, 5, 7, 2, 4, 2};

	logic [PIXEL_BITS-1:0] part_a [9];
	logic [PIXEL_BITS-1:0] part_s3 [9];
	logic [PIXEL_BITS-1:0] part_b [9];

	// Sort the three groups of three.
	always_comb begin
		logic [PIXEL_BITS-1:0] lo_v;
		logic [PIXEL_BITS-1:0] hi_v;
		part_a = taps;
		for (int k = 0; k < 9; k++) begin
			lo_v = part_a[A_LO[k]];
			hi_v = part_a[A_HI[k]];
			if (lo_v > hi_v) begin
				part_a[A_LO[k]] = hi_v;
				part_a[A_HI[k]] = lo_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s3 <= part_a;
		end
	end

	// Merge the sorted groups down to the middle element.
	always_comb begin
		logic [PIXEL_BITS-1:0] lo_v;
		logic [PIXEL_BITS-1:0] hi_v;
		part_b = part_s3;
		for (int k = 0; k < 10; k++) begin
			lo_v = part_b[B_LO[k]];
			hi_v = part_b[B_HI[k]];
			if (lo_v > hi_v) begin
				part_b[B_LO[k]] = hi_v;
				part_b[B_HI[k]] = lo_v;
			end
		end
	end

	assign median = part_b[4];

endmodule
